// ===== design/windowed_position_reorder_buffer_defines.svh =====
// Assertion helpers for the reorder buffer. They compile to nothing in synthesis.
`ifndef WINDOWED_POSITION_REORDER_BUFFER_DEFINES_SVH
`define WINDOWED_POSITION_REORDER_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WPRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define WPRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WPRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WPRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/wprb_pkg.sv =====
package wprb_pkg;

	localparam int CHROM_W = 16;
	localparam int POS_W   = 31;
	localparam int TAG_W   = 32;

	localparam logic REQ_FLUSH = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch the input transaction
		logic cut;      // recompute cutoff from current top position
		logic insert;   // sorted insert of the latched record
		logic pop;      // emit lowest entry and shift the cells down
		logic forced;   // pop is an overflow eviction
		logic last;     // result is the last one of this transaction
		logic store;    // restart the buffer with the latched record
		logic pass;     // emit the latched record directly
	} wprb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush_req;
		logic win_zero;
		logic empty;
		logic count_one;
		logic chrom_diff;
		logic drain_go;
		logic drain_last;
		logic over_full;
		logic out_free;
	} wprb_stat_t;

endpackage

// ===== design/wprb_ctrl.sv =====
module wprb_ctrl
	import wprb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  wprb_stat_t stat,
	output wprb_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_INSERT = 8'b0000_0100,
		S_CUT    = 8'b0000_1000,
		S_DRAIN  = 8'b0001_0000,
		S_FLUSH  = 8'b0010_0000,
		S_STORE  = 8'b0100_0000,
		S_PASS   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.flush_req) begin
					state_d = stat.empty ? S_IDLE : S_FLUSH;
				end else if (stat.win_zero) begin
					state_d = S_PASS;
				end else if (stat.empty) begin
					state_d = S_STORE;
				end else if (stat.chrom_diff) begin
					state_d = S_FLUSH;
				end else begin
					// cutoff of the old top, for the late flag
					cmd.cut = 1'b1;
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_CUT;
			end
			S_CUT: begin
				cmd.cut = 1'b1;
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				priority if (stat.drain_go) begin
					if (stat.out_free) begin
						cmd.pop  = 1'b1;
						cmd.last = stat.drain_last;
						if (stat.drain_last) begin
							state_d = S_IDLE;
						end
					end
				end else if (stat.over_full) begin
					if (stat.out_free) begin
						cmd.pop    = 1'b1;
						cmd.forced = 1'b1;
						cmd.last   = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.pop  = 1'b1;
					cmd.last = stat.count_one;
					if (stat.count_one) begin
						state_d = stat.flush_req ? S_IDLE : S_STORE;
					end
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_IDLE;
			end
			S_PASS: begin
				if (stat.out_free) begin
					cmd.pass = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/wprb_dpath.sv =====
module wprb_dpath
	import wprb_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [POS_W-1:0]   window_size,
	input  logic               req_type,
	input  logic [CHROM_W-1:0] chrom_id,
	input  logic [POS_W-1:0]   position,
	input  logic [TAG_W-1:0]   record_tag,
	input  wprb_cmd_t          cmd,
	output wprb_stat_t         stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TAG_W-1:0]   out_tag,
	output logic [CHROM_W-1:0] out_chrom,
	output logic [POS_W-1:0]   out_pos,
	output logic               out_late,
	output logic               out_forced,
	output logic               out_last
);

	// one spare cell holds the overflow entry until it is evicted
	localparam int NC = DEPTH + 1;
	localparam int CW = $clog2(DEPTH + 2);

	logic [POS_W-1:0]   slot_pos_q [NC];
	logic [TAG_W-1:0]   slot_tag_q [NC];
	logic [POS_W-1:0]   nxt_pos    [NC];
	logic [TAG_W-1:0]   nxt_tag    [NC];
	logic [NC-1:0]      le;
	logic [CW-1:0]      count_q;
	logic [CHROM_W-1:0] cur_chrom_q;
	logic               req_q;
	logic [CHROM_W-1:0] chrom_q;
	logic [POS_W-1:0]   pos_q;
	logic [TAG_W-1:0]   tag_q;
	logic [POS_W-1:0]   top_q;
	logic [POS_W-1:0]   cut_q;
	logic               late_q;
	logic               out_valid_q;
	logic               emit;

	function automatic logic [POS_W-1:0] cutoff_of(input logic [POS_W-1:0] top,
			input logic [POS_W-1:0] win);
		return (top <= win) ? POS_W'(1) : top - win;
	endfunction

	// cells at or below the new position stay; the buffer is sorted so this is a prefix
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			le[i] = (CW'(i) < count_q) && (slot_pos_q[i] <= pos_q);
		end
	end

	always_comb begin
		nxt_pos = slot_pos_q;
		nxt_tag = slot_tag_q;
		priority if (cmd.insert) begin
			if (!le[0]) begin
				nxt_pos[0] = pos_q;
				nxt_tag[0] = tag_q;
			end
			for (int i = 1; i < NC; i++) begin
				if (!le[i]) begin
					if (le[i-1]) begin
						nxt_pos[i] = pos_q;
						nxt_tag[i] = tag_q;
					end else begin
						nxt_pos[i] = slot_pos_q[i-1];
						nxt_tag[i] = slot_tag_q[i-1];
					end
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < NC - 1; i++) begin
				nxt_pos[i] = slot_pos_q[i+1];
				nxt_tag[i] = slot_tag_q[i+1];
			end
		end else if (cmd.store) begin
			nxt_pos[0] = pos_q;
			nxt_tag[0] = tag_q;
		end
	end

	always_ff @(posedge clk) begin
		slot_pos_q <= nxt_pos;
		slot_tag_q <= nxt_tag;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			chrom_q <= chrom_id;
			pos_q   <= position;
			tag_q   <= record_tag;
		end
		if (cmd.cut) begin
			cut_q <= cutoff_of(top_q, window_size);
		end
		if (cmd.store) begin
			top_q <= pos_q;
		end else if (cmd.insert && pos_q >= top_q) begin
			top_q <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_chrom_q <= '0;
			late_q      <= 1'b0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.store) begin
				count_q <= CW'(1);
			end
			if (cmd.store) begin
				cur_chrom_q <= chrom_q;
			end
			// only a record landing at the bottom, under the old cutoff, is late
			if (cmd.capture || cmd.pop) begin
				late_q <= 1'b0;
			end else if (cmd.insert) begin
				late_q <= !le[0] && (pos_q < cut_q);
			end
		end
	end

	assign emit = cmd.pop || cmd.pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_tag    <= slot_tag_q[0];
			out_chrom  <= cur_chrom_q;
			out_pos    <= slot_pos_q[0];
			out_late   <= late_q;
			out_forced <= cmd.forced;
			out_last   <= cmd.last;
		end else if (cmd.pass) begin
			out_tag    <= tag_q;
			out_chrom  <= chrom_q;
			out_pos    <= pos_q;
			out_late   <= 1'b0;
			out_forced <= 1'b0;
			out_last   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.flush_req  = (req_q == REQ_FLUSH);
		stat.win_zero   = (window_size == '0);
		stat.empty      = (count_q == '0);
		stat.count_one  = (count_q == CW'(1));
		stat.chrom_diff = (chrom_q != cur_chrom_q);
		stat.drain_go   = (count_q > CW'(1)) && (slot_pos_q[0] <= cut_q);
		// after this pop, would the next cell still drain? a drained buffer never overflows
		stat.drain_last = !((count_q > CW'(2)) && (slot_pos_q[1] <= cut_q));
		stat.over_full  = (count_q > CW'(DEPTH));
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== design/windowed_position_reorder_buffer.sv =====
// An insert steps through the decode, insert, cut and drain states before its first result;
// a flush or chromosome change goes from decode to the flush state, and a pass-through
// record from decode to the pass state. Results leave at one per cycle unless the output
// stalls. A new transaction is taken only in the idle state, after the last one is done.
// Reset clears the entry count, current chromosome and window size; cells are not cleared.
`include "windowed_position_reorder_buffer_defines.svh"

module windowed_position_reorder_buffer
	import wprb_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [POS_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [CHROM_W-1:0] chrom_id,
	input  logic [POS_W-1:0]   position,
	input  logic [TAG_W-1:0]   record_tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TAG_W-1:0]   out_tag,
	output logic [CHROM_W-1:0] out_chrom,
	output logic [POS_W-1:0]   out_pos,
	output logic               out_late,
	output logic               out_forced,
	output logic               out_last
);

	logic [POS_W-1:0] window_q;
	wprb_cmd_t        dp_cmd;
	wprb_stat_t       dp_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	wprb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	wprb_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (window_q),
		.req_type    (req_type),
		.chrom_id    (chrom_id),
		.position    (position),
		.record_tag  (record_tag),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_tag     (out_tag),
		.out_chrom   (out_chrom),
		.out_pos     (out_pos),
		.out_late    (out_late),
		.out_forced  (out_forced),
		.out_last    (out_last)
	);

	`WPRB_ASSERT_IMP(a_emit_has_room, clk, arst_n, dp_cmd.pop || dp_cmd.pass, !out_valid || out_ready, "result issued over a held result")
	`WPRB_ASSERT_IMP(a_pop_not_empty, clk, arst_n, dp_cmd.pop, !dp_stat.empty, "pop from empty buffer")
	`WPRB_ASSERT_IMP(a_insert_has_room, clk, arst_n, dp_cmd.insert, !dp_stat.over_full, "insert into overflowed buffer")
	`WPRB_ASSERT_NXT(a_accept_goes_busy, clk, arst_n, in_valid && in_ready, !in_ready, "second transaction taken while busy")

endmodule
